// ===== hdl/bpe_pkg.sv =====
// bpe_pkg: shared types and constants of the balanced polynomial encoder
// no dependencies; imported by the table builder, the core, the checker and the testbench
`default_nettype none

package bpe_pkg;

  // fixed field widths
  localparam int TGT_W   = 41;
  localparam int TBL_W   = 40;
  localparam int BASE_W  = 5;
  localparam int COEF_W  = 2;
  localparam int IDX_W   = 4;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd3;
  localparam logic [TBL_W-1:0]  TABLE_CAP  = {TBL_W{1'b1}};

  // coefficient codes
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 2'sb00;
  localparam logic signed [COEF_W-1:0] COEF_POS  = 2'sb01;
  localparam logic signed [COEF_W-1:0] COEF_NEG  = 2'sb11;

  // core sequencer states
  typedef enum logic [2:0] {
    ST_BUILD,
    ST_IDLE,
    ST_SEARCH,
    ST_STEP,
    ST_EMIT
  } bpe_state_t;

endpackage

`default_nettype wire

// ===== hdl/bpe_table.sv =====
// bpe_table: power and cumulative sum tables, rebuilt one entry per cycle
// from the base register; depends on bpe_pkg
`default_nettype none

module bpe_table import bpe_pkg::*; #(
  parameter int DEGREE_BOUND = 10,
  localparam int IW = $clog2(DEGREE_BOUND)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr,
  input  wire logic [BASE_W-1:0] cfg_base,
  input  wire logic [IW-1:0]     sum_addr,
  output logic      [TBL_W-1:0]  sum_data,
  input  wire logic [IW-1:0]     pow_addr,
  output logic      [TBL_W-1:0]  pow_data,
  output logic                   busy
);

  logic [BASE_W-1:0] base_r;
  logic              busy_r;
  logic [IW-1:0]     bidx_r;
  logic [TBL_W-1:0]  p_r;
  logic [TBL_W-1:0]  s_r;
  logic [TBL_W-1:0]  pow_mem_r [DEGREE_BOUND];
  logic [TBL_W-1:0]  sum_mem_r [DEGREE_BOUND];
  logic [TBL_W-1:0]  sum_rd_r;
  logic [TBL_W-1:0]  pow_rd_r;

  logic [TBL_W+BASE_W-1:0] prod;
  logic [TBL_W:0]          s_sum;
  logic [TBL_W-1:0]        p_nxt;
  logic [TBL_W-1:0]        s_nxt;

  // next power and sum, saturating at the table cap
  always_comb begin
    prod  = p_r * base_r;
    p_nxt = (prod > {{BASE_W{1'b0}}, TABLE_CAP}) ? TABLE_CAP : prod[TBL_W-1:0];
    s_sum = {1'b0, s_r} + {1'b0, p_nxt};
    s_nxt = (s_sum > {1'b0, TABLE_CAP}) ? TABLE_CAP : s_sum[TBL_W-1:0];
    if (bidx_r == '0) begin
      p_nxt = TBL_W'(1);
      s_nxt = TBL_W'(1);
    end
  end

  // build sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      busy_r <= 1'b1;
      bidx_r <= '0;
    end else if (cfg_wr) begin
      base_r <= cfg_base;
      busy_r <= 1'b1;
      bidx_r <= '0;
    end else if (busy_r) begin
      if (bidx_r == IW'(DEGREE_BOUND - 1)) begin
        busy_r <= 1'b0;
      end else begin
        bidx_r <= bidx_r + 1'b1;
      end
    end
  end

  // table entries and running power and sum
  always_ff @(posedge clk) begin
    if (busy_r) begin
      p_r               <= p_nxt;
      s_r               <= s_nxt;
      pow_mem_r[bidx_r] <= p_nxt;
      sum_mem_r[bidx_r] <= s_nxt;
    end
  end

  // registered reads; the caller presents the address in the cycle before use
  always_ff @(posedge clk) begin
    sum_rd_r <= sum_mem_r[sum_addr];
    pow_rd_r <= pow_mem_r[pow_addr];
  end

  assign sum_data = sum_rd_r;
  assign pow_data = pow_rd_r;
  assign busy     = busy_r;

endmodule

`default_nettype wire

// ===== hdl/balanced_polynomial_encoder_core.sv =====
// Balanced polynomial encoder: a downward table search, one entry per cycle,
// feeds a shared compare and subtract unit, then coefficients stream out.
// One transaction in flight: the search, the subtract steps and the
// coefficient emission all finish before the next target is taken.
// Reset and every base write rebuild the tables, holding in_stall high
// until the rebuild is done; depends on bpe_pkg, bpe_table
`default_nettype none

module balanced_polynomial_encoder_core import bpe_pkg::*; #(
  parameter int DEGREE_BOUND = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [BASE_W-1:0]        cfg_poly_base,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [TGT_W-1:0]  in_target,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [COEF_W-1:0]      out_coefficient,
  output logic [IDX_W-1:0]              out_digit_index,
  output logic [IDX_W-1:0]              out_encoded_length,
  output logic                          out_last,
  output logic                          out_error
);

  localparam int IW = $clog2(DEGREE_BOUND);

  bpe_state_t state_r, state_nxt;

  logic [TGT_W-1:0]          t_r, t_nxt;
  logic                      neg_r, neg_nxt;
  logic                      flip_r, flip_nxt;
  logic [IW-1:0]             idx_r, idx_nxt;
  logic                      hit_r, hit_nxt;
  logic [IW-1:0]             found_r, found_nxt;
  logic [IW-1:0]             prev_r, prev_nxt;
  logic                      prev_ok_r, prev_ok_nxt;
  logic [IW-1:0]             first_r, first_nxt;
  logic                      first_ok_r, first_ok_nxt;
  logic                      err_r, err_nxt;
  logic [IW-1:0]             k_r, k_nxt;
  logic signed [COEF_W-1:0]  digit_r [DEGREE_BOUND];
  logic signed [COEF_W-1:0]  digit_nxt [DEGREE_BOUND];

  logic                      out_valid_r, out_valid_nxt;
  logic signed [COEF_W-1:0]  out_coef_r, out_coef_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic [IDX_W-1:0]          out_len_r, out_len_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_err_r, out_err_nxt;

  logic                      in_acc;
  logic                      cfg_acc;
  logic                      out_load;
  logic                      tbl_busy;
  logic [TBL_W-1:0]          tbl_sum;
  logic [TBL_W-1:0]          tbl_pow;

  logic [TGT_W-1:0]          mag;
  logic                      sum_ge;
  logic [TGT_W-1:0]          pow_ext;
  logic                      pow_gt;
  logic [TGT_W-1:0]          sub_a;
  logic [TGT_W-1:0]          sub_b;
  logic [TGT_W-1:0]          sub_d;
  logic                      repeat_deg;
  logic                      emit_last;
  logic [IW:0]               len_full;

  // power and sum tables, addressed with the next-state indices for a registered read
  bpe_table #(
    .DEGREE_BOUND (DEGREE_BOUND)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_acc),
    .cfg_base (cfg_poly_base),
    .sum_addr (idx_nxt),
    .sum_data (tbl_sum),
    .pow_addr (found_nxt),
    .pow_data (tbl_pow),
    .busy     (tbl_busy)
  );

  // shared compare and subtract unit
  always_comb begin
    mag        = in_target[TGT_W-1] ? (~in_target + 1'b1) : in_target;
    sum_ge     = {1'b0, tbl_sum} >= t_r;
    pow_ext    = {1'b0, tbl_pow};
    pow_gt     = pow_ext > t_r;
    sub_a      = pow_gt ? pow_ext : t_r;
    sub_b      = pow_gt ? t_r : pow_ext;
    sub_d      = sub_a - sub_b;
    repeat_deg = prev_ok_r && (found_r == prev_r);
    emit_last  = err_r || (k_r == first_r);
    len_full   = {1'b0, first_r} + 1'b1;
  end

  // handshake outputs
  always_comb begin
    cfg_ready = (state_r == ST_IDLE);
    cfg_acc   = cfg_valid && cfg_ready;
    in_stall  = (state_r != ST_IDLE) || cfg_valid;
    in_acc    = in_valid && !in_stall;
    out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_BUILD: begin
        if (!tbl_busy) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_acc) begin
          state_nxt = ST_BUILD;
        end else if (in_acc) begin
          state_nxt = (mag == '0) ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sum_ge) begin
          if (idx_r == '0) state_nxt = ST_STEP;
        end else begin
          state_nxt = hit_r ? ST_STEP : ST_EMIT;
        end
      end
      ST_STEP: begin
        if (repeat_deg || (pow_ext == t_r)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_EMIT: begin
        if (out_load && emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_BUILD;
    endcase
  end

  // datapath next values
  always_comb begin
    t_nxt        = t_r;
    neg_nxt      = neg_r;
    flip_nxt     = flip_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    found_nxt    = found_r;
    prev_nxt     = prev_r;
    prev_ok_nxt  = prev_ok_r;
    first_nxt    = first_r;
    first_ok_nxt = first_ok_r;
    err_nxt      = err_r;
    k_nxt        = k_r;
    digit_nxt    = digit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          t_nxt        = mag;
          neg_nxt      = in_target[TGT_W-1];
          flip_nxt     = 1'b0;
          idx_nxt      = IW'(DEGREE_BOUND - 1);
          hit_nxt      = 1'b0;
          prev_ok_nxt  = 1'b0;
          first_nxt    = '0;
          first_ok_nxt = 1'b0;
          err_nxt      = 1'b0;
          k_nxt        = '0;
          for (int i = 0; i < DEGREE_BOUND; i++) begin
            digit_nxt[i] = COEF_ZERO;
          end
        end
      end
      ST_SEARCH: begin
        if (sum_ge) begin
          found_nxt = idx_r;
          hit_nxt   = 1'b1;
          if (idx_r != '0) idx_nxt = idx_r - 1'b1;
        end else if (!hit_r) begin
          err_nxt = 1'b1;
        end
      end
      ST_STEP: begin
        if (repeat_deg) begin
          err_nxt = 1'b1;
        end else begin
          digit_nxt[found_r] = flip_r ? COEF_NEG : COEF_POS;
          if (!first_ok_r) begin
            first_nxt    = found_r;
            first_ok_nxt = 1'b1;
          end
          if (pow_gt) flip_nxt = !flip_r;
          t_nxt       = sub_d;
          prev_nxt    = found_r;
          prev_ok_nxt = 1'b1;
          idx_nxt     = found_r;
          hit_nxt     = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_load) k_nxt = k_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_coef_nxt  = out_coef_r;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = emit_last;
      out_err_nxt   = err_r;
      if (err_r) begin
        out_coef_nxt = COEF_ZERO;
        out_idx_nxt  = '0;
        out_len_nxt  = '0;
      end else begin
        out_coef_nxt = neg_r ? COEF_W'(-digit_r[k_r]) : digit_r[k_r];
        out_idx_nxt  = IDX_W'(k_r);
        out_len_nxt  = IDX_W'(len_full);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUILD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    neg_r      <= neg_nxt;
    flip_r     <= flip_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    prev_r     <= prev_nxt;
    prev_ok_r  <= prev_ok_nxt;
    first_r    <= first_nxt;
    first_ok_r <= first_ok_nxt;
    err_r      <= err_nxt;
    k_r        <= k_nxt;
    digit_r    <= digit_nxt;
    out_coef_r <= out_coef_nxt;
    out_idx_r  <= out_idx_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_coefficient    = out_coef_r;
  assign out_digit_index    = out_idx_r;
  assign out_encoded_length = out_len_r;
  assign out_last           = out_last_r;
  assign out_error          = out_err_r;

endmodule

`default_nettype wire

// ===== hdl/bpe_checker.sv =====
// bpe_checker: port-level assertions for the balanced polynomial encoder
// depends on bpe_pkg; bound to balanced_polynomial_encoder_core below
`default_nettype none

module bpe_checker import bpe_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     cfg_valid,
  input wire logic                     cfg_ready,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [COEF_W-1:0] out_coefficient,
  input wire logic [IDX_W-1:0]         out_digit_index,
  input wire logic [IDX_W-1:0]         out_encoded_length,
  input wire logic                     out_last,
  input wire logic                     out_error
);

  // stalled result holds its coefficient, index, last and error flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coefficient) &&
    $stable(out_digit_index) && $stable(out_last) && $stable(out_error))
    else $error("stalled result changed");

  // error result is a lone final transaction with empty encoding
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_encoded_length == '0) &&
    (out_coefficient == COEF_ZERO) && (out_digit_index == '0))
    else $error("malformed error result");

  // final coefficient sits at the top degree of the encoding
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_error |->
    out_digit_index == IDX_W'(out_encoded_length - 1'b1))
    else $error("last coefficient at wrong degree");

  // coefficient code outside -1..+1 never shows
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coefficient != 2'sb10)
    else $error("coefficient out of range");

  // a base write blocks input while the tables rebuild
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
    else $error("input open during table rebuild");

endmodule

bind balanced_polynomial_encoder_core bpe_checker u_bpe_checker (.*);

`default_nettype wire

// ===== dv/balanced_polynomial_encoder_core_tb.sv =====
// testbench for balanced_polynomial_encoder_core: greedy balanced-digit predictor,
// random bursts on the input side, patterned stalls on the result side
// depends on bpe_pkg and the core under hdl
`default_nettype none

module balanced_polynomial_encoder_core_tb;
  import bpe_pkg::*;

  localparam int DEGREE_BOUND    = 10;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 3 * DEGREE_BOUND + 2 + 8;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int REPORT_CAP      = 60;
  localparam logic [BASE_W-1:0] FIXED_BASES [6] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd3};

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         len;
    logic                     last;
    logic                     err;
  } digit_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

  // expected coefficient stream, built from its own copy of the power tables
  class balanced_digit_book;
    logic [BASE_W-1:0] base;
    logic [63:0]       power_tbl [DEGREE_BOUND];
    logic [63:0]       sum_tbl   [DEGREE_BOUND];
    digit_result_t     expected_digits [$];
    int                failures;
    int                reported;

    function new();
      failures = 0;
      reported = 0;
      load_base(BASE_RESET);
    endfunction

    // powers and running sums, both saturating at the table cap
    function void load_base(logic [BASE_W-1:0] b);
      logic [63:0] p;
      logic [63:0] s;
      base = b;
      p = 64'd1;
      s = 64'd1;
      power_tbl[0] = 64'd1;
      sum_tbl[0]   = 64'd1;
      for (int i = 1; i < DEGREE_BOUND; i++) begin
        p = p * 64'(b);
        if (p > 64'(TABLE_CAP)) p = 64'(TABLE_CAP);
        s = s + p;
        if (s > 64'(TABLE_CAP)) s = 64'(TABLE_CAP);
        power_tbl[i] = p;
        sum_tbl[i]   = s;
      end
    endfunction

    function longint unsigned reach();
      return sum_tbl[DEGREE_BOUND-1];
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    function void push_error();
      digit_result_t r;
      r = '{coef: COEF_ZERO, idx: '0, len: '0, last: 1'b1, err: 1'b1};
      expected_digits.push_back(r);
    endfunction

    // greedy balanced encoding of one accepted target
    function void note_target(logic [TGT_W-1:0] raw);
      logic [63:0]              resid;
      logic signed [COEF_W-1:0] digits [DEGREE_BOUND];
      logic                     neg;
      logic                     flip;
      logic                     done;
      int                       limit;
      int                       prev;
      int                       first;
      int                       found;
      int                       len;
      digit_result_t            r;
      neg   = raw[TGT_W-1];
      resid = neg ? (64'd1 << TGT_W) - 64'(raw) : 64'(raw);
      foreach (digits[i]) digits[i] = COEF_ZERO;
      // zero is a single zero coefficient
      if (resid == 64'd0) begin
        r = '{coef: COEF_ZERO, idx: '0, len: IDX_W'(1), last: 1'b1, err: 1'b0};
        expected_digits.push_back(r);
        return;
      end
      limit = DEGREE_BOUND - 1;
      prev  = DEGREE_BOUND;
      first = -1;
      flip  = 1'b0;
      done  = 1'b0;
      for (int st = 0; st <= DEGREE_BOUND && !done; st++) begin
        found = -1;
        for (int i = 0; i <= limit; i++) begin
          if (sum_tbl[i] >= resid) begin
            found = i;
            break;
          end
        end
        // out of reach, or the same degree twice in a row
        if (found < 0 || found == prev) break;
        if (first < 0) first = found;
        limit = found;
        digits[found] = flip ? COEF_NEG : COEF_POS;
        if (power_tbl[found] == resid) begin
          done = 1'b1;
        end else if (power_tbl[found] > resid) begin
          flip  = !flip;
          resid = power_tbl[found] - resid;
        end else begin
          resid = resid - power_tbl[found];
        end
        prev = found;
      end
      if (!done || first < 0) begin
        push_error();
        return;
      end
      len = first + 1;
      for (int k = 0; k < len; k++) begin
        r.coef = neg ? -digits[k] : digits[k];
        r.idx  = IDX_W'(k);
        r.len  = IDX_W'(len);
        r.last = (k == len - 1);
        r.err  = 1'b0;
        expected_digits.push_back(r);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        failures++;
        if (reported < REPORT_CAP) begin
          reported++;
          $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        end
      end
    endfunction

    // one accepted result against the oldest expectation
    function void check_digit(logic signed [COEF_W-1:0] coef, logic [IDX_W-1:0] idx,
                              logic [IDX_W-1:0] len, logic last, logic err);
      digit_result_t want;
      if (expected_digits.size() == 0) begin
        failures++;
        if (reported < REPORT_CAP) begin
          reported++;
          $display("%0t unexpected result: expected none, actual coefficient %0d index %0d",
                   $time, coef, idx);
        end
        return;
      end
      want = expected_digits.pop_front();
      compare_field("coefficient", want.coef, coef);
      compare_field("digit_index", want.idx, idx);
      compare_field("encoded_length", want.len, len);
      compare_field("last", want.last, last);
      compare_field("error", want.err, err);
    endfunction
  endclass

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [BASE_W-1:0]        cfg_poly_base = BASE_RESET;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic signed [TGT_W-1:0]  in_target     = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic signed [COEF_W-1:0] out_coefficient;
  logic [IDX_W-1:0]         out_digit_index;
  logic [IDX_W-1:0]         out_encoded_length;
  logic                     out_last;
  logic                     out_error;

  balanced_digit_book coef_book = new();
  int                 quiet_cycles = 0;
  stall_pattern_t     stall_mode   = STALL_NONE;
  int                 stall_left   = 0;
  int                 stall_tick   = 0;

  balanced_polynomial_encoder_core #(
    .DEGREE_BOUND(DEGREE_BOUND)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_poly_base     (cfg_poly_base),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target         (in_target),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coefficient   (out_coefficient),
    .out_digit_index   (out_digit_index),
    .out_encoded_length(out_encoded_length),
    .out_last          (out_last),
    .out_error         (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch all three channels; every transaction resets the idle count
  always @(posedge clk) begin : monitor
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready === 1'b1) begin
        coef_book.load_base(cfg_poly_base);
        moved = 1'b1;
      end
      if (in_valid && in_stall === 1'b0) begin
        coef_book.note_target(in_target);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        coef_book.check_digit(out_coefficient, out_digit_index, out_encoded_length,
                              out_last, out_error);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // receiver stall pattern, switching between modes every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  // one input transaction; valid stays up on return
  task automatic send_target(input longint value);
    in_valid  <= 1'b1;
    in_target <= value[TGT_W-1:0];
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // base write once every expected coefficient has arrived
  task automatic write_base(input logic [BASE_W-1:0] b);
    in_valid <= 1'b0;
    @(posedge clk);
    while (coef_book.pending() != 0) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_poly_base <= b;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // mostly encodable values, plus small, boundary and full-width ones
  function automatic longint pick_target(longint unsigned span_top);
    longint unsigned wide;
    longint unsigned span;
    longint unsigned edge_val;
    int unsigned     sel;
    wide = {$urandom, $urandom};
    sel  = $urandom_range(0, 99);
    if (sel < 55) begin
      span = 2 * span_top + 1;
      return longint'(wide % span) - longint'(span_top);
    end else if (sel < 70) begin
      return longint'($urandom_range(0, 40)) - 20;
    end else if (sel < 85) begin
      edge_val = span_top + $urandom_range(0, 2) - 1;
      return $urandom_range(0, 1) ? -longint'(edge_val) : longint'(edge_val);
    end
    return longint'(wide);
  endfunction

  initial begin : stimulus
    int burst_left;
    int gap;
    logic [BASE_W-1:0] b;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset base: zero, unit values, edge of reach, out of reach, field extremes
    send_target(0);
    send_target(1);
    send_target(-1);
    send_target(2);
    send_target(-2);
    send_target(13);
    send_target(29524);
    send_target(-29524);
    send_target(29525);
    send_target(-29525);
    send_target(longint'(TABLE_CAP));
    send_target(-longint'(TABLE_CAP) - 1);
    // base above three: a repeated degree
    write_base(5'd5);
    send_target(3);
    send_target(6);
    // base one: every power is one
    write_base(5'd1);
    send_target(2);
    send_target(10);
    send_target(11);
    // base 31: saturated top entries
    write_base(5'd31);
    send_target(longint'(TABLE_CAP));
    send_target(-longint'(TABLE_CAP));
    // base zero
    write_base(5'd0);
    send_target(1);
    send_target(-1);
    send_target(2);
    write_base(5'd16);
    send_target(17);
    write_base(5'd2);
    send_target(5);

    // random phases, each with its own base
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      b = (ph < 6) ? FIXED_BASES[ph] : BASE_W'($urandom_range(0, 31));
      write_base(b);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_target(pick_target(coef_book.reach()));
        // some phases run back to back with no sender gaps
        if (ph % 4 != 1) begin
          burst_left--;
          if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
              in_valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
          end
        end
      end
    end

    // drain, then watch a little longer for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (coef_book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (coef_book.failures == 0 && coef_book.pending() == 0) begin
      $display("PASS balanced_polynomial_encoder_core");
    end else begin
      $display("FAIL balanced_polynomial_encoder_core");
    end
    $finish;
  end

  // end the run when nothing has moved for too long
  initial begin : watchdog
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL balanced_polynomial_encoder_core");
    $finish;
  end

endmodule

`default_nettype wire
